FILE: design/btmx_pkg.sv
// Shared constants and node record type for the binary trie minimum-xor block.
package btmx_pkg;

  localparam int KEY_BITS  = 30;
  localparam int NODE_POOL = 8192;
  localparam int ENTRIES   = 256;

  localparam int KEY_W   = 30;
  localparam int ID_W    = 8;
  localparam int DELTA_W = 9;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam int NODE_W = $clog2(NODE_POOL);
  localparam int USED_W = $clog2(NODE_POOL + 1);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int SUM_W  = ((CNT_W > DELTA_W) ? CNT_W : DELTA_W) + 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADJUST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [NODE_W-1:0] link1;
    logic [NODE_W-1:0] link0;
    logic [CNT_W-1:0]  cnt1;
    logic [CNT_W-1:0]  cnt0;
  } node_t;

endpackage

FILE: design/binary_trie_min_xor.sv
// Binary trie minimum-xor engine: insert, count adjust and nearest-key query.
// Each command walks the trie from the top key bit down, one level per cycle: a level
// reads one node record from the node memory (registered read); insert and the update
// pass of adjust write it back through the saturating count adder. Adjust makes a check
// pass then an update pass; a full-pool insert or unused command goes straight to the
// result. One command is in flight; in_stall is high meanwhile.
// The finished result moves to an output register, so the next beat is taken while it
// waits. No clearing pass: a freshly allocated node reads as zero and the root has a
// valid flag that reset clears.
module binary_trie_min_xor
  import btmx_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CMD_W-1:0]          cmd,
  input  logic [KEY_W-1:0]          key_value,
  input  logic [ID_W-1:0]           entry_id,
  input  logic signed [DELTA_W-1:0] count_delta,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [KEY_W-1:0]          xor_distance,
  output logic [ID_W-1:0]           match_id,
  output logic [STAT_W-1:0]         status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_QRY  = 3'd4;
  localparam logic [2:0] S_LEAF = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(KEY_BITS - 1);

  node_t             node_mem [NODE_POOL];
  logic [ID_W-1:0]   leaf_mem [NODE_POOL];

  logic [2:0]                state;
  logic [LVL_W-1:0]          level;
  logic [NODE_W-1:0]         node;
  logic                      fresh;
  logic                      root_valid;
  logic [USED_W-1:0]         nodes_used;
  logic [KEY_W-1:0]          key_q;
  logic [ID_W-1:0]           id_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic [KEY_W-1:0]          res_dist;
  logic [ID_W-1:0]           res_id;
  logic [STAT_W-1:0]         res_status;

  node_t             rd_q;
  logic [ID_W-1:0]   leaf_q;
  node_t             cur;
  node_t             upd;
  logic              kbit;
  logic [NODE_W-1:0] link_sel;
  logic [NODE_W-1:0] fresh_idx;
  logic [NODE_W-1:0] ins_link;
  logic [CNT_W-1:0]  cnt_sel;
  logic [CNT_W-1:0]  cnt_new;
  logic signed [SUM_W-1:0] add_in;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]  cnt_want;
  logic [CNT_W-1:0]  cnt_other;
  logic              take;
  logic [NODE_W-1:0] rd_addr;
  logic              mem_we;
  logic [NODE_W-1:0] leaf_addr;
  logic              leaf_we;
  logic              pool_low;
  logic              out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign pool_low = nodes_used > USED_W'(NODE_POOL - KEY_BITS);
  assign fresh_idx = nodes_used[NODE_W-1:0];

  assign cur  = (fresh || (node == '0 && !root_valid)) ? '0 : rd_q;
  assign kbit = key_q[level];
  assign link_sel = kbit ? cur.link1 : cur.link0;
  assign cnt_sel  = kbit ? cur.cnt1 : cur.cnt0;
  assign ins_link = (link_sel == '0) ? fresh_idx : link_sel;

  // shared saturating count adder: +1 on insert, signed delta on adjust
  assign add_in = (state == S_INS) ? SUM_W'(1) : SUM_W'(delta_q);
  assign sum    = $signed({{(SUM_W - CNT_W){1'b0}}, cnt_sel}) + add_in;
  always_comb begin
    if (sum < 0) begin
      cnt_new = '0;
    end else if (sum > $signed(SUM_W'(ENTRIES))) begin
      cnt_new = CNT_W'(ENTRIES);
    end else begin
      cnt_new = sum[CNT_W-1:0];
    end
  end

  always_comb begin
    upd = cur;
    if (kbit) begin
      upd.cnt1 = cnt_new;
      if (state == S_INS) begin
        upd.link1 = ins_link;
      end
    end else begin
      upd.cnt0 = cnt_new;
      if (state == S_INS) begin
        upd.link0 = ins_link;
      end
    end
  end

  assign cnt_want  = kbit ? cur.cnt1 : cur.cnt0;
  assign cnt_other = kbit ? cur.cnt0 : cur.cnt1;
  assign take      = (cnt_want != '0) ? kbit : !kbit;

  always_comb begin
    rd_addr   = '0;
    leaf_addr = '0;
    mem_we    = 1'b0;
    leaf_we   = 1'b0;
    case (state)
      S_INS: begin
        mem_we    = 1'b1;
        rd_addr   = ins_link;
        leaf_addr = ins_link;
        leaf_we   = (level == '0);
      end
      S_CHK: begin
        rd_addr = (level == '0) ? '0 : link_sel;
      end
      S_UPD: begin
        mem_we  = 1'b1;
        rd_addr = link_sel;
      end
      S_QRY: begin
        rd_addr   = take ? cur.link1 : cur.link0;
        leaf_addr = rd_addr;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_q   <= node_mem[rd_addr];
    leaf_q <= leaf_mem[leaf_addr];
    if (mem_we) begin
      node_mem[node] <= upd;
    end
    if (leaf_we) begin
      leaf_mem[leaf_addr] <= id_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      root_valid <= 1'b0;
      nodes_used <= USED_W'(1);
      fresh      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_q      <= key_value;
            id_q       <= entry_id;
            delta_q    <= count_delta;
            node       <= '0;
            fresh      <= 1'b0;
            level      <= LVL_TOP;
            res_dist   <= '0;
            res_id     <= '0;
            case (cmd)
              CMD_INSERT: begin
                if (pool_low) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_INS;
                end
              end
              CMD_ADJUST: begin
                res_status <= ST_OK;
                state      <= S_CHK;
              end
              CMD_QUERY: begin
                res_status <= ST_OK;
                state      <= S_QRY;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_INS: begin
          if (node == '0) begin
            root_valid <= 1'b1;
          end
          if (link_sel == '0) begin
            nodes_used <= nodes_used + USED_W'(1);
          end
          fresh <= (link_sel == '0);
          node  <= ins_link;
          level <= level - LVL_W'(1);
          if (level == '0) begin
            state <= S_DONE;
          end
        end
        S_CHK: begin
          if (link_sel == '0) begin
            res_status <= ST_MISSING;
            state      <= S_DONE;
          end else if (level == '0) begin
            node  <= '0;
            level <= LVL_TOP;
            state <= S_UPD;
          end else begin
            node  <= link_sel;
            level <= level - LVL_W'(1);
          end
        end
        S_UPD: begin
          node  <= link_sel;
          level <= level - LVL_W'(1);
          if (level == '0) begin
            state <= S_DONE;
          end
        end
        S_QRY: begin
          if (cnt_want == '0 && cnt_other == '0) begin
            res_dist   <= '0;
            res_status <= ST_EMPTY;
            state      <= S_DONE;
          end else begin
            if (take != kbit) begin
              res_dist[level] <= 1'b1;
            end
            node  <= rd_addr;
            level <= level - LVL_W'(1);
            if (level == '0) begin
              state <= S_LEAF;
            end
          end
        end
        S_LEAF: begin
          res_id <= leaf_q;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            xor_distance <= res_dist;
            match_id     <= res_id;
            status       <= res_status;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= USED_W'(NODE_POOL))
    else $error("node pool overrun");

  a_pool_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> nodes_used >= $past(nodes_used))
    else $error("allocation count went backwards");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> xor_distance == '0 && match_id == '0)
    else $error("failed beat carries nonzero payload");

  a_write_walk: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == S_INS || state == S_UPD)
    else $error("node write outside an updating walk");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for binary_trie_min_xor: trie predictor, queued driver, checking monitor.
module tb_top;
  import btmx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 100;
  localparam int RAND_PER_PHASE = 110;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;

  typedef struct {
    logic [CMD_W-1:0]          op;
    logic [KEY_W-1:0]          key;
    logic [ID_W-1:0]           id;
    logic signed [DELTA_W-1:0] delta;
  } trie_cmd_t;

  typedef struct {
    logic [KEY_W-1:0]  distance;
    logic [ID_W-1:0]   id;
    logic [STAT_W-1:0] st;
  } trie_res_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CMD_W-1:0]          cmd = '0;
  logic [KEY_W-1:0]          key_value = '0;
  logic [ID_W-1:0]           entry_id = '0;
  logic signed [DELTA_W-1:0] count_delta = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [KEY_W-1:0]          xor_distance;
  logic [ID_W-1:0]           match_id;
  logic [STAT_W-1:0]         status;

  binary_trie_min_xor uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .key_value(key_value), .entry_id(entry_id), .count_delta(count_delta),
    .out_valid(out_valid), .out_stall(out_stall),
    .xor_distance(xor_distance), .match_id(match_id), .status(status)
  );

  // predictor state
  bit [NODE_W-1:0] trie_link [2*NODE_POOL];
  bit [CNT_W-1:0]  trie_count [2*NODE_POOL];
  bit [ID_W-1:0]   leaf_tag [NODE_POOL];
  int              nodes_alloc = 1;

  trie_cmd_t        cmd_backlog[$];
  trie_res_t        trie_answers[$];
  logic [KEY_W-1:0] known_keys[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int beats_fed = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int cycle_count = 0;

  function automatic bit [CNT_W-1:0] clamp_count(int v);
    if (v < 0) return '0;
    if (v > ENTRIES) return CNT_W'(ENTRIES);
    return CNT_W'(v);
  endfunction

  function automatic trie_res_t walk_trie(trie_cmd_t c);
    trie_res_t r;
    int node;
    int slot;
    int want;
    int take;
    int d;
    r.distance = '0;
    r.id = '0;
    r.st = ST_OK;
    node = 0;
    d = c.delta;
    case (c.op)
      CMD_INSERT: begin
        if (NODE_POOL - nodes_alloc < KEY_BITS) begin
          r.st = ST_FULL;
          return r;
        end
        for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
          slot = node * 2 + c.key[lvl];
          if (trie_link[slot] == 0) begin
            trie_link[nodes_alloc*2] = '0;
            trie_link[nodes_alloc*2+1] = '0;
            trie_count[nodes_alloc*2] = '0;
            trie_count[nodes_alloc*2+1] = '0;
            trie_link[slot] = NODE_W'(nodes_alloc);
            nodes_alloc++;
          end
          trie_count[slot] = clamp_count(int'(trie_count[slot]) + 1);
          node = trie_link[slot];
        end
        leaf_tag[node] = c.id;
      end
      CMD_ADJUST: begin
        for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
          slot = node * 2 + c.key[lvl];
          if (trie_link[slot] == 0) begin
            r.st = ST_MISSING;
            return r;
          end
          node = trie_link[slot];
        end
        node = 0;
        for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
          slot = node * 2 + c.key[lvl];
          trie_count[slot] = clamp_count(int'(trie_count[slot]) + d);
          node = trie_link[slot];
        end
      end
      CMD_QUERY: begin
        for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
          want = c.key[lvl];
          if (trie_count[node*2+want] != 0) take = want;
          else if (trie_count[node*2+(want^1)] != 0) take = want ^ 1;
          else begin
            r.distance = '0;
            r.st = ST_EMPTY;
            return r;
          end
          if (take != want) r.distance[lvl] = 1'b1;
          node = trie_link[node*2+take];
        end
        r.id = leaf_tag[node];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] any_known();
    if (known_keys.size() == 0) return KEY_W'($urandom);
    return known_keys[$urandom_range(known_keys.size() - 1)];
  endfunction

  function automatic logic [KEY_W-1:0] near_key();
    int span;
    span = $urandom_range(1, 16);
    return any_known() ^ KEY_W'($urandom & ((1 << span) - 1));
  endfunction

  function automatic trie_cmd_t random_beat();
    trie_cmd_t b;
    int pick;
    int roll;
    b.key = KEY_W'($urandom);
    b.id = ID_W'($urandom);
    b.delta = DELTA_W'(int'($urandom_range(510)) - 255);
    pick = $urandom_range(99);
    roll = $urandom_range(99);
    if (pick < 40) begin
      b.op = CMD_INSERT;
      if (roll >= 80) b.key = any_known();
      else if (roll >= 55) b.key = near_key();
      known_keys = {known_keys, b.key};
    end else if (pick < 65) begin
      b.op = CMD_ADJUST;
      b.key = (roll < 80) ? any_known() : near_key();
      if ($urandom_range(99) < 75) b.delta = DELTA_W'(int'($urandom_range(5)) - 2);
    end else if (pick < 95) begin
      b.op = CMD_QUERY;
      if (roll < 60) b.key = near_key();
    end else begin
      b.op = CMD_SPARE;
    end
    return b;
  endfunction

  task automatic queue_beat(logic [CMD_W-1:0] op, logic [KEY_W-1:0] key,
                            logic [ID_W-1:0] id, int delta);
    trie_cmd_t b;
    b.op = op;
    b.key = key;
    b.id = id;
    b.delta = DELTA_W'(delta);
    if (op == CMD_INSERT) known_keys = {known_keys, key};
    cmd_backlog = {cmd_backlog, b};
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_valid || trie_answers.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    trie_cmd_t nxt;
    trie_res_t pred;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pred = walk_trie('{cmd, key_value, entry_id, count_delta});
        trie_answers = {trie_answers, pred};
        beats_fed++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          cmd <= nxt.op;
          key_value <= nxt.key;
          entry_id <= nxt.id;
          count_delta <= nxt.delta;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    trie_res_t exp_res;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (trie_answers.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatches++;
        end else begin
          exp_res = trie_answers.pop_front();
          status_seen[status]++;
          if (xor_distance !== exp_res.distance) begin
            $error("xor_distance: expected %0h, got %0h", exp_res.distance, xor_distance);
            mismatches++;
          end
          if (match_id !== exp_res.id) begin
            $error("match_id: expected %0h, got %0h", exp_res.id, match_id);
            mismatches++;
          end
          if (status !== exp_res.st) begin
            $error("status: expected %0d, got %0d", exp_res.st, status);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty trie, missing keys, unused command, extremes, saturation
    queue_beat(CMD_QUERY, '0, '0, 0);
    queue_beat(CMD_ADJUST, KEY_ONES, '0, 1);
    queue_beat(CMD_SPARE, KEY_ONES, 8'hFF, -1);
    queue_beat(CMD_INSERT, KEY_ONES, 8'hFF, 0);
    queue_beat(CMD_INSERT, '0, 8'hA5, 0);
    queue_beat(CMD_QUERY, KEY_ONES, '0, 0);
    queue_beat(CMD_QUERY, '0, 8'hFF, 0);
    queue_beat(CMD_QUERY, 30'h2AAAAAAA, '0, 0);
    queue_beat(CMD_ADJUST, 30'h3FFFFFFE, '0, 1);
    queue_beat(CMD_ADJUST, '0, '0, -255);
    queue_beat(CMD_QUERY, '0, '0, 0);
    queue_beat(CMD_ADJUST, KEY_ONES, '0, -1);
    queue_beat(CMD_QUERY, 30'h155, '0, 0);
    queue_beat(CMD_ADJUST, '0, '0, 255);
    queue_beat(CMD_ADJUST, '0, '0, 255);
    queue_beat(CMD_INSERT, '0, 8'h5A, 0);
    queue_beat(CMD_ADJUST, '0, '0, -255);
    queue_beat(CMD_QUERY, KEY_ONES, '0, 0);
    queue_beat(CMD_ADJUST, KEY_ONES, '0, 2);
    queue_beat(CMD_INSERT, 30'h15555555, 8'h3C, 0);
    queue_beat(CMD_QUERY, 30'h15555554, '0, 0);
    queue_beat(CMD_ADJUST, 30'h15555555, '0, 0);
    wait_drained();

    // random traffic under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(78, 0);
        2: set_idling(0, 78);
        default: set_idling(26, 26);
      endcase
      repeat (RAND_PER_PHASE) cmd_backlog = {cmd_backlog, random_beat()};
      wait_drained();
    end

    // fill the node pool with fresh keys
    set_idling(0, 0);
    while (NODE_POOL - nodes_alloc >= KEY_BITS) begin
      repeat (10) queue_beat(CMD_INSERT, KEY_W'($urandom), ID_W'($urandom), 0);
      wait_drained();
    end

    // pool full: an existing key is refused too
    set_idling(26, 26);
    queue_beat(CMD_INSERT, any_known(), 8'h81, 0);
    repeat (4) queue_beat(CMD_INSERT, KEY_W'($urandom), ID_W'($urandom), 0);
    repeat (30) cmd_backlog = {cmd_backlog, random_beat()};
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Fed %0d commands: %0d ok, %0d pool full, %0d trie empty, %0d key missing.",
             beats_fed, status_seen[ST_OK], status_seen[ST_FULL],
             status_seen[ST_EMPTY], status_seen[ST_MISSING]);
    $display("Trie grew to %0d of %0d nodes; %0d mismatches.",
             nodes_alloc, NODE_POOL, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/btmx_pkg.sv
design/binary_trie_min_xor.sv
test/tb_top.sv
